@@ design/x86_instruction_byte_encoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// x86 encoder assertion macros
// Assertion helpers used by the encoder RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef X86_INSTRUCTION_BYTE_ENCODER_CORE_MACROS_SVH
`define X86_INSTRUCTION_BYTE_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define X86E_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define X86E_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define X86E_ASSERT(label, clk, rst_n, prop, msg)
`define X86E_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ design/x86e_pkg.sv @@
// ----------------------------------------------------------------------------
// x86 encoder package
// Item types, instruction kind codes and shared limits.
// ----------------------------------------------------------------------------
package x86e_pkg;

  localparam int unsigned MaxBytes = 11;
  localparam int unsigned LenW = 4;

  // Instruction kinds, in emitter order.
  localparam logic [6:0] KindMovRr = 7'd0, KindMovRi = 7'd1, KindMovRm = 7'd2,
    KindMovMr = 7'd3, KindMovMi = 7'd4, KindMovsxBm = 7'd5, KindMovsxWm = 7'd6,
    KindMovzxBm = 7'd7, KindMovzxWm = 7'd8, KindMovsxBr = 7'd9, KindMovsxWr = 7'd10,
    KindMovzxBr = 7'd11, KindMovzxWr = 7'd12, KindMovbMr = 7'd13, KindMovwMr = 7'd14,
    KindLea = 7'd15, KindPushR = 7'd16, KindPushI = 7'd17, KindPushM = 7'd18,
    KindPopR = 7'd19, KindXchg = 7'd20, KindCdq = 7'd21, KindAddRr = 7'd22,
    KindAddRi = 7'd23, KindAddMi = 7'd24, KindSubRr = 7'd25, KindSubRi = 7'd26,
    KindAdcRr = 7'd27, KindSbbRr = 7'd28, KindImulRr = 7'd29, KindMul = 7'd30,
    KindImul = 7'd31, KindIdiv = 7'd32, KindDiv = 7'd33, KindNeg = 7'd34,
    KindNot = 7'd35, KindAndRr = 7'd36, KindAndRi = 7'd37, KindOrRr = 7'd38,
    KindXorRr = 7'd39, KindShlCl = 7'd40, KindShrCl = 7'd41, KindSarCl = 7'd42,
    KindShlI = 7'd43, KindShrI = 7'd44, KindSarI = 7'd45, KindShld = 7'd46,
    KindShrd = 7'd47, KindCmpRr = 7'd48, KindCmpRi = 7'd49, KindTest = 7'd50,
    KindSetcc = 7'd51, KindJmp = 7'd52, KindJcc = 7'd53, KindCall = 7'd54,
    KindCallR = 7'd55, KindRet = 7'd56, KindNop = 7'd57, KindInt80 = 7'd58,
    KindFldD = 7'd59, KindFldQ = 7'd60, KindFstpD = 7'd61, KindFstpQ = 7'd62,
    KindFildD = 7'd63, KindFistpD = 7'd64, KindFisttpD = 7'd65, KindFaddp = 7'd66,
    KindFsubp = 7'd67, KindFmulp = 7'd68, KindFdivp = 7'd69, KindFchs = 7'd70,
    KindFabs = 7'd71, KindFcomip = 7'd72, KindFstpSt0 = 7'd73, KindFxch = 7'd74,
    KindFldSt0 = 7'd75;

  typedef struct packed {
    logic [6:0]         cmd;
    logic [2:0]         reg_first;
    logic [2:0]         reg_second;
    logic signed [31:0] displacement;
    logic [31:0]        immediate;
    logic [3:0]         condition;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [31:0] byte_offset;
    logic        last_byte;
  } out_item_t;

  // One encoded instruction: bytes in order and their count.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } enc_t;

endpackage

@@ design/x86e_encode.sv @@
// ----------------------------------------------------------------------------
// x86 encoder combinational encoder
// Turns one instruction into its byte string and length.
// ----------------------------------------------------------------------------
module x86e_encode (
  input  x86e_pkg::in_item_t item,
  output x86e_pkg::enc_t     enc
);
  import x86e_pkg::*;

  logic [7:0]  buf_b [MaxBytes];
  logic [LenW-1:0] n;
  logic [2:0]  a, b;
  logic [31:0] d, imm;
  logic        d8, i8;
  logic [6:0]  k;

  function automatic logic [7:0] movx_op(input logic [1:0] i);
    case (i)
      2'd0: movx_op = 8'hBE;
      2'd1: movx_op = 8'hBF;
      2'd2: movx_op = 8'hB6;
      default: movx_op = 8'hB7;
    endcase
  endfunction

  function automatic logic [2:0] unary_ext(input logic [2:0] i);
    case (i)
      3'd0: unary_ext = 3'd4;
      3'd1: unary_ext = 3'd5;
      3'd2: unary_ext = 3'd7;
      3'd3: unary_ext = 3'd6;
      3'd4: unary_ext = 3'd3;
      default: unary_ext = 3'd2;
    endcase
  endfunction

  function automatic logic [2:0] shift_ext(input logic [1:0] i);
    case (i)
      2'd0: shift_ext = 3'd4;
      2'd1: shift_ext = 3'd5;
      default: shift_ext = 3'd7;
    endcase
  endfunction

  function automatic logic [15:0] fmem(input logic [2:0] i);
    case (i)
      3'd0: fmem = {8'hD9, 8'd0};
      3'd1: fmem = {8'hDD, 8'd0};
      3'd2: fmem = {8'hD9, 8'd3};
      3'd3: fmem = {8'hDD, 8'd3};
      3'd4: fmem = {8'hDB, 8'd0};
      3'd5: fmem = {8'hDB, 8'd3};
      default: fmem = {8'hDB, 8'd1};
    endcase
  endfunction

  function automatic logic [15:0] fpair(input logic [3:0] i);
    case (i)
      4'd0: fpair = 16'hDEC1;
      4'd1: fpair = 16'hDEE9;
      4'd2: fpair = 16'hDEC9;
      4'd3: fpair = 16'hDEF9;
      4'd4: fpair = 16'hD9E0;
      4'd5: fpair = 16'hD9E1;
      4'd6: fpair = 16'hDFF1;
      4'd7: fpair = 16'hDDD8;
      4'd8: fpair = 16'hD9C9;
      default: fpair = 16'hD9C0;
    endcase
  endfunction

  function automatic void put(input logic [7:0] v);
    if (n < LenW'(MaxBytes)) begin
      buf_b[n] = v;
      n = n + LenW'(1);
    end
  endfunction

  function automatic void put32(input logic [31:0] v);
    put(v[7:0]); put(v[15:8]); put(v[23:16]); put(v[31:24]);
  endfunction

  function automatic void rr(input logic [7:0] r, input logic [2:0] m);
    put({2'b11, r[2:0], m});
  endfunction

  function automatic void mem(input logic [2:0] r);
    logic [7:0] f;
    f = {2'b00, r, 3'b000};
    if (b == 3'd4) begin
      if (d == 32'd0) begin put(8'h04 | f); put(8'h24); end
      else if (d8) begin put(8'h44 | f); put(8'h24); put(d[7:0]); end
      else begin put(8'h84 | f); put(8'h24); put32(d); end
    end else if (b == 3'd5) begin
      if (d8) begin put(8'h45 | f); put(d[7:0]); end
      else begin put(8'h85 | f); put32(d); end
    end else begin
      if (d == 32'd0) put(f | {5'd0, b});
      else if (d8) begin put(8'h40 | f | {5'd0, b}); put(d[7:0]); end
      else begin put(8'h80 | f | {5'd0, b}); put32(d); end
    end
  endfunction

  function automatic void alu_ri(input logic [2:0] ext, input logic [7:0] acc);
    if (i8) begin put(8'h83); rr({5'd0, ext}, a); put(imm[7:0]); end
    else if (a == 3'd0) begin put(acc); put32(imm); end
    else begin put(8'h81); rr({5'd0, ext}, a); put32(imm); end
  endfunction

  always_comb begin
    logic [15:0] fp;
    a   = item.reg_first;
    b   = item.reg_second;
    d   = item.displacement;
    imm = item.immediate;
    d8  = (d + 32'd128) < 32'd256;
    i8  = (imm + 32'd128) < 32'd256;
    k   = item.cmd;
    n   = '0;
    fp  = '0;
    for (int i = 0; i < MaxBytes; i++) buf_b[i] = '0;

    // Append helpers are the functions above: each put bumps n.
    // Register field of the memory form is chosen per kind, then ModRM follows.
    unique case (1'b1)
      (k == KindMovRr): begin put(8'h89); rr({5'd0, b}, a); end
      (k == KindMovRi): begin put(8'hB8 + {5'd0, a}); put32(imm); end
      (k == KindMovRm): begin put(8'h8B); mem(a); end
      (k == KindMovMr): begin put(8'h89); mem(a); end
      (k == KindMovMi): begin put(8'hC7); mem(3'd0); put32(imm); end
      (k >= KindMovsxBm && k <= KindMovzxWm): begin
        put(8'h0F); put(movx_op(2'(k - KindMovsxBm))); mem(a);
      end
      (k >= KindMovsxBr && k <= KindMovzxWr): begin
        put(8'h0F); put(movx_op(2'(k - KindMovsxBr))); rr({5'd0, a}, b);
      end
      (k == KindMovbMr): begin put(8'h88); mem(a); end
      (k == KindMovwMr): begin put(8'h66); put(8'h89); mem(a); end
      (k == KindLea):    begin put(8'h8D); mem(a); end
      (k == KindPushR):  put(8'h50 + {5'd0, a});
      (k == KindPushI):  begin put(8'h68); put32(imm); end
      (k == KindPushM):  begin put(8'hFF); mem(3'd6); end
      (k == KindPopR):   put(8'h58 + {5'd0, a});
      (k == KindXchg): begin
        if (a == 3'd0) put(8'h90 + {5'd0, b});
        else if (b == 3'd0) put(8'h90 + {5'd0, a});
        else begin put(8'h87); rr({5'd0, a}, b); end
      end
      (k == KindCdq):   put(8'h99);
      (k == KindAddRr): begin put(8'h01); rr({5'd0, b}, a); end
      (k == KindAddRi): alu_ri(3'd0, 8'h05);
      (k == KindAddMi): begin
        if (i8) begin put(8'h83); mem(3'd0); put(imm[7:0]); end
        else begin put(8'h81); mem(3'd0); put32(imm); end
      end
      (k == KindSubRr):  begin put(8'h29); rr({5'd0, b}, a); end
      (k == KindSubRi):  alu_ri(3'd5, 8'h2D);
      (k == KindAdcRr):  begin put(8'h11); rr({5'd0, b}, a); end
      (k == KindSbbRr):  begin put(8'h19); rr({5'd0, b}, a); end
      (k == KindImulRr): begin put(8'h0F); put(8'hAF); rr({5'd0, a}, b); end
      (k >= KindMul && k <= KindNot): begin
        put(8'hF7); rr({5'd0, unary_ext(3'(k - KindMul))}, a);
      end
      (k == KindAndRr): begin put(8'h21); rr({5'd0, b}, a); end
      (k == KindAndRi): begin
        if (a == 3'd0) begin put(8'h25); put32(imm); end
        else begin put(8'h81); rr(8'd4, a); put32(imm); end
      end
      (k == KindOrRr):  begin put(8'h09); rr({5'd0, b}, a); end
      (k == KindXorRr): begin put(8'h31); rr({5'd0, b}, a); end
      (k >= KindShlCl && k <= KindSarCl): begin
        put(8'hD3); rr({5'd0, shift_ext(2'(k - KindShlCl))}, a);
      end
      (k >= KindShlI && k <= KindSarI): begin
        if (imm[7:0] == 8'd1) begin
          put(8'hD1); rr({5'd0, shift_ext(2'(k - KindShlI))}, a);
        end else begin
          put(8'hC1); rr({5'd0, shift_ext(2'(k - KindShlI))}, a); put(imm[7:0]);
        end
      end
      (k == KindShld):  begin put(8'h0F); put(8'hA5); rr({5'd0, b}, a); end
      (k == KindShrd):  begin put(8'h0F); put(8'hAD); rr({5'd0, b}, a); end
      (k == KindCmpRr): begin put(8'h39); rr({5'd0, b}, a); end
      (k == KindCmpRi): alu_ri(3'd7, 8'h3D);
      (k == KindTest):  begin put(8'h85); rr({5'd0, b}, a); end
      (k == KindSetcc): begin
        put(8'h0F); put(8'h90 + {4'd0, item.condition}); rr(8'd0, a);
      end
      (k == KindJmp): begin put(8'hE9); put32(imm); end
      (k == KindJcc): begin
        put(8'h0F); put(8'h80 + {4'd0, item.condition}); put32(imm);
      end
      (k == KindCall):  begin put(8'hE8); put32(imm); end
      (k == KindCallR): begin put(8'hFF); rr(8'd2, a); end
      (k == KindRet):   put(8'hC3);
      (k == KindNop):   put(8'h90);
      (k == KindInt80): begin put(8'hCD); put(8'h80); end
      (k >= KindFldD && k <= KindFisttpD): begin
        fp = fmem(3'(k - KindFldD));
        put(fp[15:8]); mem(fp[2:0]);
      end
      (k >= KindFaddp && k <= KindFldSt0): begin
        fp = fpair(4'(k - KindFaddp));
        put(fp[15:8]); put(fp[7:0]);
      end
      default: n = '0;
    endcase

    for (int i = 0; i < MaxBytes; i++) enc.bytes[i] = buf_b[i];
    enc.len = n;
  end

endmodule

@@ design/x86instruction_byte_encoder_placeholder.sv @@
// ----------------------------------------------------------------------------
// x86 encoder byte sequencer
// Holds one encoded instruction and hands out its bytes one per cycle while take is high.
// ----------------------------------------------------------------------------
module x86e_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  x86e_pkg::enc_t      enc,
  input  logic                take,
  output logic                busy,
  output logic [7:0]          cur_byte,
  output logic                cur_last
);
  import x86e_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes_r;
  logic [LenW-1:0]          len_r, idx_r;
  logic [LenW-1:0]          idx_nxt;

  assign busy     = (idx_r < len_r);
  assign cur_byte = bytes_r[idx_r];
  assign cur_last = (idx_r + LenW'(1) == len_r);

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = idx_r + LenW'(1);
    if (load) idx_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      len_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) len_r <= enc.len;
    end
    if (load) bytes_r <= enc.bytes;
  end

endmodule

@@ design/x86_instruction_byte_encoder_core.sv @@
// ----------------------------------------------------------------------------
// x86 instruction byte encoder, top level
// Encodes 32-bit x86 instructions into a stream of bytes with offsets.
// ----------------------------------------------------------------------------
//  channel | direction | payload        | handshake
//  in_     | input     | x86e in_item_t | in_valid / in_stall
//  out_    | output    | out_item_t     | out_valid / out_stall
//
// Each accepted item is registered, encoded by combinational logic into up to
// eleven bytes and loaded into a byte buffer; the buffer sends one byte per
// cycle unless out_stall holds a full output register. An item moves from the
// input register into the buffer, and its bytes into the output register. The
// next instruction enters the buffer on the cycle its predecessor's final byte
// moves into the output register, so bytes stream with no gaps; an unknown kind
// emits nothing but still passes through the buffer, leaving a gap in the stream.
// Reset clears the code position, buffer count and valid flags.
`include "x86_instruction_byte_encoder_core_macros.svh"
module x86_instruction_byte_encoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  x86e_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output x86e_pkg::out_item_t  out_item
);
  import x86e_pkg::*;

  in_item_t   hold_r;
  logic       hold_v_r;
  enc_t       enc;
  logic       busy, cur_last, take, load, out_free, in_acc;
  logic [7:0] cur_byte;
  logic [31:0] pos_r, pos_nxt;
  out_item_t  out_r;
  logic       out_v_r;

  x86e_encode u_enc (.item(hold_r), .enc(enc));

  // The output register frees when empty or when its item is taken.
  assign out_free = !out_v_r || !out_stall;
  // A byte moves from the buffer to the output register.
  assign take     = busy && out_free;
  // The held instruction enters the buffer when it is empty or its last byte leaves.
  assign load     = hold_v_r && (!busy || (take && cur_last));
  // The input register is free when empty or moving into the buffer.
  assign in_stall = hold_v_r && !load;
  assign in_acc   = in_valid && !in_stall;

  x86e_seq u_seq (
    .clk(clk), .rst_n(rst_n), .load(load), .enc(enc), .take(take),
    .busy(busy), .cur_byte(cur_byte), .cur_last(cur_last)
  );

  assign pos_nxt = take ? pos_r + 32'd1 : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      pos_r    <= '0;
    end else begin
      if (in_acc) hold_v_r <= 1'b1;
      else if (load) hold_v_r <= 1'b0;
      if (out_free) out_v_r <= take;
      pos_r <= pos_nxt;
    end
    if (in_acc) hold_r <= in_item;
    if (take) out_r <= '{code_byte: cur_byte, byte_offset: pos_r, last_byte: cur_last};
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  `X86E_ASSERT_NEXT(a_pos_step, clk, rst_n, take, pos_r == $past(pos_r) + 32'd1, "position skip")
  `X86E_ASSERT_NEXT(a_out_hold, clk, rst_n, out_v_r && out_stall, out_v_r && $stable(out_r), "output lost")
  `X86E_ASSERT(a_no_overrun, clk, rst_n, !(load && busy && !take), "buffer overrun")

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// x86 instruction byte encoder testbench
// Drives random and directed instructions through the encoder and checks each
// emitted byte, its code offset and the final-byte flag against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
  import x86e_pkg::*;

  // Kind numbers past the last instruction, which emit nothing.
  localparam logic [6:0] KindUnknownFirst = 7'd76;
  localparam logic [6:0] KindUnknownLast = 7'h7F;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned CycleLimit = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  x86_instruction_byte_encoder_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Pending instructions, the bytes we expect back, and the predicted code offset.
  in_item_t instr_queue[$];
  out_item_t byte_queue[$];
  bit [31:0] code_pos;
  int unsigned mismatches;
  int unsigned cycles;
  // Idle percentages for sender and receiver, changed phase by phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  logic hold_req;
  logic [7:0] enc_bytes[$];

  function automatic logic fits_byte(logic [31:0] v);
    logic [31:0] s;
    begin
      s = v + 32'd128;
      return s < 32'd256;
    end
  endfunction

  task automatic put_word(logic [31:0] v);
    begin
      enc_bytes.push_back(v[7:0]);
      enc_bytes.push_back(v[15:8]);
      enc_bytes.push_back(v[23:16]);
      enc_bytes.push_back(v[31:24]);
    end
  endtask

  // Append the ModRM (and SIB, displacement) bytes of a memory operand.
  task automatic put_mem(logic [2:0] rf, logic [2:0] base, logic [31:0] disp);
    logic [7:0] r;
    logic [7:0] bs;
    begin
      r = {2'b00, rf, 3'b000};
      bs = {5'd0, base};
      if (base == 3'd4) begin
        if (disp == 32'd0) begin
          enc_bytes.push_back(8'h04 | r);
          enc_bytes.push_back(8'h24);
        end else if (fits_byte(disp)) begin
          enc_bytes.push_back(8'h44 | r);
          enc_bytes.push_back(8'h24);
          enc_bytes.push_back(disp[7:0]);
        end else begin
          enc_bytes.push_back(8'h84 | r);
          enc_bytes.push_back(8'h24);
          put_word(disp);
        end
      end else if (base == 3'd5) begin
        // EBP as base has no mod 00 form, so a zero displacement takes disp8.
        if (fits_byte(disp)) begin
          enc_bytes.push_back(8'h45 | r);
          enc_bytes.push_back(disp[7:0]);
        end else begin
          enc_bytes.push_back(8'h85 | r);
          put_word(disp);
        end
      end else begin
        if (disp == 32'd0) begin
          enc_bytes.push_back(r | bs);
        end else if (fits_byte(disp)) begin
          enc_bytes.push_back(8'h40 | r | bs);
          enc_bytes.push_back(disp[7:0]);
        end else begin
          enc_bytes.push_back(8'h80 | r | bs);
          put_word(disp);
        end
      end
    end
  endtask

  function automatic logic [7:0] rr(logic [2:0] rg, logic [2:0] rm);
    return {2'b11, rg, rm};
  endfunction

  // ALU with immediate: sign-extended imm8, then the EAX short form, then 0x81.
  task automatic put_alu_imm(logic [2:0] ext, logic [7:0] acc_op, logic [2:0] r,
                             logic [31:0] imm);
    begin
      if (fits_byte(imm)) begin
        enc_bytes.push_back(8'h83);
        enc_bytes.push_back(rr(ext, r));
        enc_bytes.push_back(imm[7:0]);
      end else if (r == 3'd0) begin
        enc_bytes.push_back(acc_op);
        put_word(imm);
      end else begin
        enc_bytes.push_back(8'h81);
        enc_bytes.push_back(rr(ext, r));
        put_word(imm);
      end
    end
  endtask

  // Encode one instruction and queue its bytes with offsets.
  task automatic predict_bytes(in_item_t it);
    logic [2:0] a;
    logic [2:0] b;
    logic [31:0] d;
    logic [31:0] imm;
    logic [7:0] op;
    logic [2:0] ext;
    out_item_t ob;
    begin
      a = it.reg_first;
      b = it.reg_second;
      d = it.displacement;
      imm = it.immediate;
      enc_bytes.delete();
      case (it.cmd)
        KindMovRr: begin enc_bytes.push_back(8'h89); enc_bytes.push_back(rr(b, a)); end
        KindMovRi: begin enc_bytes.push_back(8'hB8 + {5'd0, a}); put_word(imm); end
        KindMovRm: begin enc_bytes.push_back(8'h8B); put_mem(a, b, d); end
        KindMovMr: begin enc_bytes.push_back(8'h89); put_mem(a, b, d); end
        KindMovMi: begin enc_bytes.push_back(8'hC7); put_mem(3'd0, b, d); put_word(imm); end
        KindMovsxBm, KindMovsxWm, KindMovzxBm, KindMovzxWm,
        KindMovsxBr, KindMovsxWr, KindMovzxBr, KindMovzxWr: begin
          case (it.cmd)
            KindMovsxBm, KindMovsxBr: op = 8'hBE;
            KindMovsxWm, KindMovsxWr: op = 8'hBF;
            KindMovzxBm, KindMovzxBr: op = 8'hB6;
            default: op = 8'hB7;
          endcase
          enc_bytes.push_back(8'h0F);
          enc_bytes.push_back(op);
          if (it.cmd <= KindMovzxWm) put_mem(a, b, d);
          else enc_bytes.push_back(rr(a, b));
        end
        KindMovbMr: begin enc_bytes.push_back(8'h88); put_mem(a, b, d); end
        KindMovwMr: begin
          enc_bytes.push_back(8'h66);
          enc_bytes.push_back(8'h89);
          put_mem(a, b, d);
        end
        KindLea: begin enc_bytes.push_back(8'h8D); put_mem(a, b, d); end
        KindPushR: enc_bytes.push_back(8'h50 + {5'd0, a});
        KindPushI: begin enc_bytes.push_back(8'h68); put_word(imm); end
        KindPushM: begin enc_bytes.push_back(8'hFF); put_mem(3'd6, b, d); end
        KindPopR: enc_bytes.push_back(8'h58 + {5'd0, a});
        KindXchg: begin
          if (a == 3'd0) enc_bytes.push_back(8'h90 + {5'd0, b});
          else if (b == 3'd0) enc_bytes.push_back(8'h90 + {5'd0, a});
          else begin enc_bytes.push_back(8'h87); enc_bytes.push_back(rr(a, b)); end
        end
        KindCdq: enc_bytes.push_back(8'h99);
        KindAddRr: begin enc_bytes.push_back(8'h01); enc_bytes.push_back(rr(b, a)); end
        KindAddRi: put_alu_imm(3'd0, 8'h05, a, imm);
        KindAddMi: begin
          if (fits_byte(imm)) begin
            enc_bytes.push_back(8'h83);
            put_mem(3'd0, b, d);
            enc_bytes.push_back(imm[7:0]);
          end else begin
            enc_bytes.push_back(8'h81);
            put_mem(3'd0, b, d);
            put_word(imm);
          end
        end
        KindSubRr: begin enc_bytes.push_back(8'h29); enc_bytes.push_back(rr(b, a)); end
        KindSubRi: put_alu_imm(3'd5, 8'h2D, a, imm);
        KindAdcRr: begin enc_bytes.push_back(8'h11); enc_bytes.push_back(rr(b, a)); end
        KindSbbRr: begin enc_bytes.push_back(8'h19); enc_bytes.push_back(rr(b, a)); end
        KindImulRr: begin
          enc_bytes.push_back(8'h0F);
          enc_bytes.push_back(8'hAF);
          enc_bytes.push_back(rr(a, b));
        end
        KindMul, KindImul, KindIdiv, KindDiv, KindNeg, KindNot: begin
          case (it.cmd)
            KindMul: ext = 3'd4;
            KindImul: ext = 3'd5;
            KindIdiv: ext = 3'd7;
            KindDiv: ext = 3'd6;
            KindNeg: ext = 3'd3;
            default: ext = 3'd2;
          endcase
          enc_bytes.push_back(8'hF7);
          enc_bytes.push_back(rr(ext, a));
        end
        KindAndRr: begin enc_bytes.push_back(8'h21); enc_bytes.push_back(rr(b, a)); end
        KindAndRi: begin
          // AND has no imm8 short form here, only the EAX one.
          if (a == 3'd0) begin
            enc_bytes.push_back(8'h25);
          end else begin
            enc_bytes.push_back(8'h81);
            enc_bytes.push_back(rr(3'd4, a));
          end
          put_word(imm);
        end
        KindOrRr: begin enc_bytes.push_back(8'h09); enc_bytes.push_back(rr(b, a)); end
        KindXorRr: begin enc_bytes.push_back(8'h31); enc_bytes.push_back(rr(b, a)); end
        KindShlCl, KindShrCl, KindSarCl, KindShlI, KindShrI, KindSarI: begin
          case (it.cmd)
            KindShlCl, KindShlI: ext = 3'd4;
            KindShrCl, KindShrI: ext = 3'd5;
            default: ext = 3'd7;
          endcase
          if (it.cmd <= KindSarCl) begin
            enc_bytes.push_back(8'hD3);
            enc_bytes.push_back(rr(ext, a));
          end else if (imm[7:0] == 8'd1) begin
            enc_bytes.push_back(8'hD1);
            enc_bytes.push_back(rr(ext, a));
          end else begin
            enc_bytes.push_back(8'hC1);
            enc_bytes.push_back(rr(ext, a));
            enc_bytes.push_back(imm[7:0]);
          end
        end
        KindShld, KindShrd: begin
          enc_bytes.push_back(8'h0F);
          enc_bytes.push_back(it.cmd == KindShld ? 8'hA5 : 8'hAD);
          enc_bytes.push_back(rr(b, a));
        end
        KindCmpRr: begin enc_bytes.push_back(8'h39); enc_bytes.push_back(rr(b, a)); end
        KindCmpRi: put_alu_imm(3'd7, 8'h3D, a, imm);
        KindTest: begin enc_bytes.push_back(8'h85); enc_bytes.push_back(rr(b, a)); end
        KindSetcc: begin
          enc_bytes.push_back(8'h0F);
          enc_bytes.push_back({4'h9, it.condition});
          enc_bytes.push_back(rr(3'd0, a));
        end
        KindJmp: begin enc_bytes.push_back(8'hE9); put_word(imm); end
        KindJcc: begin
          enc_bytes.push_back(8'h0F);
          enc_bytes.push_back({4'h8, it.condition});
          put_word(imm);
        end
        KindCall: begin enc_bytes.push_back(8'hE8); put_word(imm); end
        KindCallR: begin enc_bytes.push_back(8'hFF); enc_bytes.push_back(rr(3'd2, a)); end
        KindRet: enc_bytes.push_back(8'hC3);
        KindNop: enc_bytes.push_back(8'h90);
        KindInt80: begin enc_bytes.push_back(8'hCD); enc_bytes.push_back(8'h80); end
        KindFldD, KindFldQ, KindFstpD, KindFstpQ, KindFildD, KindFistpD,
        KindFisttpD: begin
          case (it.cmd)
            KindFldD: begin op = 8'hD9; ext = 3'd0; end
            KindFldQ: begin op = 8'hDD; ext = 3'd0; end
            KindFstpD: begin op = 8'hD9; ext = 3'd3; end
            KindFstpQ: begin op = 8'hDD; ext = 3'd3; end
            KindFildD: begin op = 8'hDB; ext = 3'd0; end
            KindFistpD: begin op = 8'hDB; ext = 3'd3; end
            default: begin op = 8'hDB; ext = 3'd1; end
          endcase
          enc_bytes.push_back(op);
          put_mem(ext, b, d);
        end
        KindFaddp: begin enc_bytes.push_back(8'hDE); enc_bytes.push_back(8'hC1); end
        KindFsubp: begin enc_bytes.push_back(8'hDE); enc_bytes.push_back(8'hE9); end
        KindFmulp: begin enc_bytes.push_back(8'hDE); enc_bytes.push_back(8'hC9); end
        KindFdivp: begin enc_bytes.push_back(8'hDE); enc_bytes.push_back(8'hF9); end
        KindFchs: begin enc_bytes.push_back(8'hD9); enc_bytes.push_back(8'hE0); end
        KindFabs: begin enc_bytes.push_back(8'hD9); enc_bytes.push_back(8'hE1); end
        KindFcomip: begin enc_bytes.push_back(8'hDF); enc_bytes.push_back(8'hF1); end
        KindFstpSt0: begin enc_bytes.push_back(8'hDD); enc_bytes.push_back(8'hD8); end
        KindFxch: begin enc_bytes.push_back(8'hD9); enc_bytes.push_back(8'hC9); end
        KindFldSt0: begin enc_bytes.push_back(8'hD9); enc_bytes.push_back(8'hC0); end
        default: ;  // Unknown kinds emit nothing and leave the offset alone.
      endcase
      for (int k = 0; k < enc_bytes.size(); k++) begin
        ob.code_byte = enc_bytes[k];
        ob.byte_offset = code_pos;
        ob.last_byte = (k == enc_bytes.size() - 1);
        byte_queue.push_back(ob);
        code_pos = code_pos + 32'd1;
      end
    end
  endtask

  // Random displacement or immediate, biased toward the disp8 / disp32 boundaries.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(0, 255) - 32'd128;
      2: return {$urandom_range(0, 1) ? 32'hFFFFFF7F : 32'h00000080};
      3: return $urandom_range(0, 3) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_instr(logic noise);
    in_item_t it;
    begin
      it.cmd = noise ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, KindFldSt0));
      it.reg_first = 3'($urandom_range(0, 7));
      it.reg_second = 3'($urandom_range(0, 7));
      it.displacement = pick_value();
      it.immediate = pick_value();
      it.condition = 4'($urandom_range(0, 15));
      return it;
    end
  endfunction

  function automatic in_item_t make_instr(logic [6:0] cmd, logic [2:0] a, logic [2:0] b,
                                          logic [31:0] d, logic [31:0] imm, logic [3:0] cc);
    in_item_t it;
    begin
      it.cmd = cmd;
      it.reg_first = a;
      it.reg_second = b;
      it.displacement = d;
      it.immediate = imm;
      it.condition = cc;
      return it;
    end
  endfunction

  // Driver: offers the next pending instruction, holding it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || !in_stall) begin
      // The current item (if any) was taken at this edge, so offer the next one.
      if (instr_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= instr_queue[0];
        predict_bytes(instr_queue.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req) begin
      hold_cycles <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted byte with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (byte_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h at offset %08h", out_item.code_byte,
                   out_item.byte_offset);
      end else begin
        exp_b = byte_queue.pop_front();
        if (out_item !== exp_b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h @%08h last=%0b, got %02h @%08h last=%0b",
                     exp_b.code_byte, exp_b.byte_offset, exp_b.last_byte,
                     out_item.code_byte, out_item.byte_offset, out_item.last_byte);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    begin
      while (instr_queue.size() != 0 || in_valid || byte_queue.size() != 0)
        @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, addressing corner cases and short forms.
    instr_queue.push_back(make_instr(KindMovMr, 3'd7, 3'd4, 32'd0, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindMovMr, 3'd0, 3'd4, 32'hFFFFFF80, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindMovMr, 3'd1, 3'd4, 32'h80000000, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindMovMr, 3'd2, 3'd5, 32'd0, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindMovMr, 3'd3, 3'd5, 32'h7FFFFFFF, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindMovMr, 3'd6, 3'd3, 32'd127, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindMovMr, 3'd6, 3'd3, 32'd128, 32'd0, 4'd0));
    // Longest instruction: mov [esp+disp32], imm32.
    instr_queue.push_back(make_instr(KindMovMi, 3'd0, 3'd4, 32'h12345678,
                                     32'hFFFFFFFF, 4'd0));
    instr_queue.push_back(make_instr(KindMovRi, 3'd7, 3'd0, 32'd0, 32'hA5A5A5A5, 4'd0));
    instr_queue.push_back(make_instr(KindAddRi, 3'd0, 3'd0, 32'd0, 32'hFFFFFF80, 4'd0));
    instr_queue.push_back(make_instr(KindAddRi, 3'd0, 3'd0, 32'd0, 32'h00000080, 4'd0));
    instr_queue.push_back(make_instr(KindSubRi, 3'd5, 3'd0, 32'd0, 32'hFFFFFF7F, 4'd0));
    instr_queue.push_back(make_instr(KindCmpRi, 3'd0, 3'd0, 32'd0, 32'h7FFFFFFF, 4'd0));
    instr_queue.push_back(make_instr(KindAndRi, 3'd0, 3'd0, 32'd0, 32'd5, 4'd0));
    instr_queue.push_back(make_instr(KindAndRi, 3'd4, 3'd0, 32'd0, 32'd5, 4'd0));
    instr_queue.push_back(make_instr(KindAddMi, 3'd0, 3'd5, 32'd4, 32'd100, 4'd0));
    instr_queue.push_back(make_instr(KindShlI, 3'd2, 3'd0, 32'd0, 32'hFFFFFF01, 4'd0));
    instr_queue.push_back(make_instr(KindShlI, 3'd2, 3'd0, 32'd0, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindXchg, 3'd0, 3'd6, 32'd0, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindXchg, 3'd3, 3'd0, 32'd0, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindXchg, 3'd3, 3'd7, 32'd0, 32'd0, 4'd0));
    instr_queue.push_back(make_instr(KindSetcc, 3'd1, 3'd0, 32'd0, 32'd0, 4'hF));
    instr_queue.push_back(make_instr(KindJcc, 3'd0, 3'd0, 32'd0, 32'h80000000, 4'h0));
    instr_queue.push_back(make_instr(KindUnknownLast, 3'd7, 3'd7, 32'hFFFFFFFF,
                                     32'hFFFFFFFF, 4'hF));
    instr_queue.push_back(make_instr(KindUnknownFirst, 3'd0, 3'd0, 32'd0, 32'd0, 4'd0));
    // Every kind once, random operands.
    for (int k = 0; k <= KindFldSt0; k++) begin
      in_item_t it;
      it = random_instr(1'b0);
      it.cmd = 7'(k);
      instr_queue.push_back(it);
    end
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 49) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 49) : 0;
      for (int n = 0; n < RandomItems / 4; n++)
        instr_queue.push_back(random_instr($urandom_range(0, 19) == 0));
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering items.
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (30) @(posedge clk);
    if (mismatches == 0 && byte_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
